>>> rtl/swdc_pkg.sv
// Shared types and constants for the sliding-window distinct counter.
package swdc_pkg;

   localparam int TIME_W            = 32;
   localparam int KEY_W             = 10;
   localparam int COUNT_W           = 11;
   localparam int NATIONS_DEF       = 1024;
   localparam int QUEUE_DEPTH_DEF   = 4096;
   localparam logic [TIME_W-1:0] DEFAULT_WINDOW = 32'd86400;

   // One arrival as kept in the ring.
   typedef struct packed {
      logic [TIME_W-1:0] arrival_time;
      logic [KEY_W-1:0]  key_id;
   } ring_word_type;

   // Ring commands from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic push;
      logic pop;
   } ring_ctl_type;

   // Ring status back to the sequencer.
   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

endpackage

>>> rtl/swdc_ring.sv
// Arrival ring: ordered (time, key) memory with head, tail and fill count.
module swdc_ring #(
   parameter int QUEUE_DEPTH = swdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swdc_pkg::ring_ctl_type  ctl,
   input  swdc_pkg::ring_word_type push_word,
   output swdc_pkg::ring_word_type head_word,
   output swdc_pkg::ring_stat_type stat
);
   import swdc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_POS = PW'(QUEUE_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

   ring_word_type ring_mem [QUEUE_DEPTH];

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [PW-1:0] rd_addr;
   ring_word_type rd_word_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctl.pop) begin
         head_in = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
      if (ctl.push) begin
         tail_in = (tail_ff == LAST_POS) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
   end

   // read the new head in the same cycle as a pop
   assign rd_addr = head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         ring_mem[tail_ff] <= push_word;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= ring_mem[rd_addr];
      end
   end

   assign head_word  = rd_word_ff;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == FULL_FILL);

endmodule

>>> rtl/sliding_window_distinct_counter_unit.sv
// Sliding-window distinct key counter: sequencer, key table and output word.
//
// Input words (req_) carry an arrival time, a key and an end-of-group flag;
// times must be nondecreasing. A word is taken when req_valid is high and
// req_stall is low. Each word first pops ring entries that have left the
// window (clearing a key's presence when the entry is its latest arrival),
// then records the arrival. When end_of_group is set, one result word
// (distinct count, sticky overflow) appears on rsp_ and is held while
// rsp_stall is high; the next input word is taken meanwhile.
// Sequence: after acceptance an item passes ST_HEAD, ST_INS and ST_UPD (a
// full ring drops it at ST_INS); each expired ring entry it pops adds a
// pass through ST_POP back to ST_HEAD, and an emitting word waits in ST_FIN
// while the previous result is still held. The per-key table is one
// 1-read/1-write memory and every step waits for its registered read.
// After reset the key table is swept clear, one entry a cycle, over all
// NATIONS entries (1024 by default) with req_stall high; csr_ writes of the
// window length are taken at any time. A window length of 0 acts as 1.
module sliding_window_distinct_counter_unit #(
   parameter int NATIONS     = swdc_pkg::NATIONS_DEF,
   parameter int QUEUE_DEPTH = swdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swdc_pkg::TIME_W-1:0]    req_arrival_time,
   input  logic [swdc_pkg::KEY_W-1:0]     req_key_id,
   input  logic                           req_end_of_group,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [swdc_pkg::COUNT_W-1:0]   rsp_distinct_count,
   output logic                           rsp_overflow,
   input  logic                           csr_wr_en,
   input  logic [swdc_pkg::TIME_W-1:0]    csr_wr_data
);
   import swdc_pkg::*;

   localparam int KW = $clog2(NATIONS);
   localparam int LW = $clog2(NATIONS + 1);
   localparam logic [KW-1:0] LAST_KEY = KW'(NATIONS - 1);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_HEAD  = 7'b0000100,
      ST_POP   = 7'b0001000,
      ST_INS   = 7'b0010000,
      ST_UPD   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              present;
      logic [TIME_W-1:0] seen_time;
   } key_word_type;

   key_word_type key_mem [NATIONS];

   state_type         state_ff, state_in;
   logic [KW-1:0]     clr_idx_ff, clr_idx_in;
   logic [TIME_W-1:0] window_ff, window_in;
   logic [LW-1:0]     live_ff, live_in;
   logic              ovf_ff, ovf_in;

   logic [TIME_W-1:0] item_time_ff, item_time_in;
   logic [KEY_W-1:0]  item_key_ff, item_key_in;
   logic              item_emit_ff, item_emit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic          key_rd_en, key_wr_en;
   logic [KW-1:0] key_rd_addr, key_wr_addr;
   key_word_type  key_wr_data;
   key_word_type  key_rd_ff;

   ring_ctl_type  ring_ctl;
   ring_stat_type ring_stat;
   ring_word_type ring_head_word;
   ring_word_type ring_push_word;

   logic [TIME_W-1:0] win_eff;
   logic [TIME_W-1:0] age;
   logic              expired;
   logic              key_ok;
   logic              accept;
   logic              out_free;
   logic              finish;
   logic              load_rsp;

   swdc_ring #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ring_ctl),
      .push_word(ring_push_word),
      .head_word(ring_head_word),
      .stat     (ring_stat)
   );

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign win_eff  = (window_ff == '0) ? TIME_W'(1) : window_ff;
   assign age      = item_time_ff - ring_head_word.arrival_time;
   assign expired  = !ring_stat.empty && (age >= win_eff);
   assign key_ok   = (32'(item_key_ff) < 32'(NATIONS));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign ring_push_word.arrival_time = item_time_ff;
   assign ring_push_word.key_id       = item_key_ff;

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      live_in      = live_ff;
      ovf_in       = ovf_ff;
      item_time_in = item_time_ff;
      item_key_in  = item_key_ff;
      item_emit_in = item_emit_ff;
      ring_ctl     = '0;
      key_rd_en    = 1'b0;
      key_rd_addr  = KW'(item_key_ff);
      key_wr_en    = 1'b0;
      key_wr_addr  = KW'(item_key_ff);
      key_wr_data  = '{present: 1'b1, seen_time: item_time_ff};
      finish       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            key_wr_en   = 1'b1;
            key_wr_addr = clr_idx_ff;
            key_wr_data = '0;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_KEY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // keep the head entry on the read port while waiting
            ring_ctl.rd_en = 1'b1;
            if (accept) begin
               item_time_in = req_arrival_time;
               item_key_in  = req_key_id;
               item_emit_in = req_end_of_group;
               state_in     = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (expired) begin
               key_rd_en   = 1'b1;
               key_rd_addr = KW'(ring_head_word.key_id);
               state_in    = ST_POP;
            end else begin
               state_in = ST_INS;
            end
         end
         ST_POP: begin
            // drop presence only if this entry is the key's latest arrival
            if (key_rd_ff.present &&
                key_rd_ff.seen_time == ring_head_word.arrival_time) begin
               key_wr_en   = 1'b1;
               key_wr_addr = KW'(ring_head_word.key_id);
               key_wr_data = '0;
               live_in     = live_ff - 1'b1;
            end
            ring_ctl.pop   = 1'b1;
            ring_ctl.rd_en = 1'b1;
            state_in       = ST_HEAD;
         end
         ST_INS: begin
            if (key_ok && !ring_stat.full) begin
               ring_ctl.push = 1'b1;
               key_rd_en     = 1'b1;
               state_in      = ST_UPD;
            end else begin
               if (key_ok) begin
                  ovf_in = 1'b1;
               end
               finish = 1'b1;
            end
         end
         ST_UPD: begin
            key_wr_en = 1'b1;
            if (!key_rd_ff.present) begin
               live_in = live_ff + 1'b1;
            end
            finish = 1'b1;
         end
         ST_FIN: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      load_rsp = 1'b0;
      if (finish) begin
         if (!item_emit_ff) begin
            state_in = ST_IDLE;
         end else if (out_free) begin
            load_rsp = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_FIN;
         end
      end
   end

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = COUNT_W'(live_in);
         rsp_ovf_in   = ovf_in;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_count_in = rsp_count_ff;
         rsp_ovf_in   = rsp_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         window_ff    <= DEFAULT_WINDOW;
         live_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         window_ff    <= window_in;
         live_ff      <= live_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_time_ff <= item_time_in;
      item_key_ff  <= item_key_in;
      item_emit_ff <= item_emit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= key_wr_data;
      end
      if (key_rd_en) begin
         key_rd_ff <= key_mem[key_rd_addr];
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distinct_count = rsp_count_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

>>> sim/sliding_window_distinct_counter_unit_tb.sv
// Self-checking testbench for the sliding-window distinct key counter.
`timescale 1ns / 100ps

module sliding_window_distinct_counter_unit_tb;
   import swdc_pkg::*;

   localparam int          SETTLE_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int          PHASE_WORDS   = 150;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               ovf;
   } count_word_type;

   // Tracks key presence in the window and queues the count words due.
   class distinct_tracker;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] seen_at[NATIONS_DEF];
      bit                is_live[NATIONS_DEF];
      logic [TIME_W-1:0] ring_stamp[QUEUE_DEPTH_DEF];
      logic [KEY_W-1:0]  ring_owner[QUEUE_DEPTH_DEF];
      int unsigned       rd_ptr;
      int unsigned       wr_ptr;
      int unsigned       depth_used;
      logic [COUNT_W-1:0] live_keys;
      bit                dropped_any;
      count_word_type    counts_due[$];
      int                faults;

      function new();
         span        = DEFAULT_WINDOW;
         rd_ptr      = 0;
         wr_ptr      = 0;
         depth_used  = 0;
         live_keys   = '0;
         dropped_any = 1'b0;
         faults      = 0;
         foreach (is_live[i]) is_live[i] = 1'b0;
      endfunction

      function void set_window(logic [TIME_W-1:0] v);
         span = v;
      endfunction

      function int pending();
         return counts_due.size();
      endfunction

      function void note_arrival(logic [TIME_W-1:0] stamp, logic [KEY_W-1:0] k, logic eog);
         logic [TIME_W-1:0] win;
         logic [TIME_W-1:0] age;
         logic [KEY_W-1:0]  old_key;
         count_word_type    due;
         win = (span == '0) ? 32'd1 : span;
         // drop head entries that left the window; stale ones leave presence alone
         while (depth_used > 0) begin
            age = stamp - ring_stamp[rd_ptr];
            if (age < win) break;
            old_key = ring_owner[rd_ptr];
            if (is_live[old_key] && seen_at[old_key] == ring_stamp[rd_ptr]) begin
               is_live[old_key] = 1'b0;
               live_keys--;
            end
            rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
            depth_used--;
         end
         if (depth_used >= QUEUE_DEPTH_DEF) begin
            dropped_any = 1'b1;
         end else begin
            ring_stamp[wr_ptr] = stamp;
            ring_owner[wr_ptr] = k;
            wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
            depth_used++;
            seen_at[k] = stamp;
            if (!is_live[k]) begin
               is_live[k] = 1'b1;
               live_keys++;
            end
         end
         if (eog) begin
            due.count = live_keys;
            due.ovf   = dropped_any;
            counts_due = {counts_due, due};
         end
      endfunction

      function void check_count(logic [COUNT_W-1:0] got_count, logic got_ovf);
         count_word_type due;
         if (counts_due.size() == 0) begin
            if (faults < 10)
               $display("count word with none pending: distinct_count %0d overflow %0b",
                        got_count, got_ovf);
            faults++;
            return;
         end
         due = counts_due.pop_front();
         if (got_count !== due.count || got_ovf !== due.ovf) begin
            if (faults < 10)
               $display("count mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                        due.count, got_count, due.ovf, got_ovf);
            faults++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [TIME_W-1:0] req_arrival_time;
   logic [KEY_W-1:0]  req_key_id;
   logic req_end_of_group;
   logic rsp_valid;
   logic rsp_stall;
   logic [COUNT_W-1:0] rsp_distinct_count;
   logic rsp_overflow;
   logic csr_wr_en;
   logic [TIME_W-1:0] csr_wr_data;

   distinct_tracker tracker;
   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int unsigned cycles = 0;

   sliding_window_distinct_counter_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_arrival_time   (req_arrival_time),
      .req_key_id         (req_key_id),
      .req_end_of_group   (req_end_of_group),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // stall the count words at random
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_count(rsp_distinct_count, rsp_overflow);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic [TIME_W-1:0] stamp, input logic [KEY_W-1:0] k,
                            input logic eog);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_arrival_time <= stamp;
      req_key_id       <= k;
      req_end_of_group <= eog;
      do @(posedge clock); while (req_stall);
      tracker.note_arrival(stamp, k, eog);
   endtask

   // hold off until every count word is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [TIME_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_window(v);
   endtask

   task automatic run_directed();
      // default window: boundary, stale entry of a re-seen key
      send_word(32'd0, 10'd0, 1'b1);
      send_word(32'd0, 10'd1023, 1'b1);
      send_word(32'd100, 10'd0, 1'b0);
      send_word(32'd86399, 10'd5, 1'b1);
      send_word(32'd86400, 10'd6, 1'b1);
      send_word(32'd86500, 10'd7, 1'b1);
      write_window(32'd1);
      send_word(32'd86500, 10'd8, 1'b1);
      send_word(32'd86501, 10'd9, 1'b1);
      // zero window acts as one
      write_window(32'd0);
      send_word(32'd86501, 10'd10, 1'b0);
      send_word(32'd86501, 10'd9, 1'b1);
      send_word(32'd86502, 10'd11, 1'b1);
      // widest window, time wrap and time going back
      write_window(32'hFFFF_FFFF);
      send_word(32'hFFFF_FFF0, 10'd12, 1'b1);
      send_word(32'hFFFF_FFFF, 10'h2AA, 1'b0);
      send_word(32'h0000_0005, 10'd13, 1'b1);
      send_word(32'h0000_0006, 10'd14, 1'b0);
      send_word(32'h0000_0005, 10'd15, 1'b1);
      write_window(32'd1000);
      send_word(32'h0000_0003, 10'h155, 1'b0);
      send_word(32'h0000_0003, 10'd1, 1'b1);
   endtask

   task automatic run_random_phase(input logic [TIME_W-1:0] win, input int n);
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] scale;
      logic [KEY_W-1:0]  k;
      logic              eog;
      int                r;
      stamp = $urandom();
      scale = (win > 32'h00FF_FFFF) ? 32'h00FF_FFFF : (win >> 2) + 1;
      write_window(win);
      for (int i = 0; i < n; i++) begin
         idle_on = !(i >= n / 3 && i < n / 2);
         r = $urandom_range(0, 99);
         if (r < 3)
            stamp = stamp + win;
         else if (r < 5)
            stamp = stamp - $urandom_range(1, 64);
         else
            stamp = stamp + $urandom_range(0, scale);
         // a small key pool keeps re-seen keys and stale entries common
         if ($urandom_range(0, 9) < 7)
            k = 10'($urandom_range(0, 31));
         else
            k = 10'($urandom_range(0, 1023));
         eog = (i == n - 1) || ($urandom_range(0, 2) == 0);
         send_word(stamp, k, eog);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_arrival_time = '0;
      req_key_id       = '0;
      req_end_of_group = 1'b0;
      rsp_stall        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random_phase(32'd1, PHASE_WORDS);
      run_random_phase(32'd5, PHASE_WORDS);
      run_random_phase(32'd64, PHASE_WORDS);
      run_random_phase(32'd1000, PHASE_WORDS);
      run_random_phase(DEFAULT_WINDOW, PHASE_WORDS);
      run_random_phase(32'h0001_0000, PHASE_WORDS);
      run_random_phase(32'h8000_0000, PHASE_WORDS);
      run_random_phase(32'hFFFF_FFFF, PHASE_WORDS);
      run_random_phase($urandom_range(2, 32'h0000_FFFF), PHASE_WORDS);
      run_random_phase(32'd16, 40);
      settle();

      if (tracker.faults == 0 && tracker.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
